FILE: design/gsn_pkg.sv
// Shared types, constants and step functions for the gamepad stick and trigger normalizer.
`timescale 1ns / 1ps

package gsn_pkg;

    // pipeline depth: entry, squares, sum, 16 root steps, divide setup, 16 divide steps, output
    localparam int STAGES = 37;
    localparam int ROOT_STEPS = 16;
    localparam int DIV_STEPS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DZ = 2'd1;
    localparam logic [1:0] CFG_TRIG_TH  = 2'd2;

    localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
    localparam logic [7:0]  TRIG_TH_RST  = 8'd30;

    localparam logic [14:0] STICK_FULL = 15'h7fff;
    localparam logic [7:0]  TRIG_FULL  = 8'hff;
    localparam logic [15:0] DIR_LIMIT  = 16'h7fff;

    // divider lanes
    localparam int LN_LX = 0;
    localparam int LN_LY = 1;
    localparam int LN_LM = 2;
    localparam int LN_RX = 3;
    localparam int LN_RY = 4;
    localparam int LN_RM = 5;
    localparam int LN_TL = 6;
    localparam int LN_TR = 7;

    typedef struct packed {
        logic [1:0]  ctrl;
        logic [15:0] btn;
        logic [31:0] pkt;
    } t_pass;

    typedef struct packed {
        logic [23:0] num;
        logic [7:0]  den;
    } t_trig;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic [16:0] ax;
        logic [16:0] ay;
    } t_axis;

    typedef struct packed {
        t_pass           pass;
        t_trig [1:0]     trg;
        t_axis [1:0]     st;
    } t_sa;

    typedef struct packed {
        t_pass            pass;
        t_trig [1:0]      trg;
        t_axis [1:0]      st;
        logic [1:0][30:0] sxx;
        logic [1:0][30:0] syy;
        logic [1:0][29:0] dz2;
    } t_sb;

    typedef struct packed {
        logic [31:0] s_sh;
        logic [16:0] rem;
        logic [15:0] root;
    } t_root;

    typedef struct packed {
        t_pass        pass;
        t_trig [1:0]  trg;
        t_axis [1:0]  st;
        logic  [1:0]  act;
        t_root [1:0]  rt;
    } t_sqs;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] num;
        logic [15:0] den;
        logic [15:0] q;
    } t_lane;

    typedef struct packed {
        t_pass       pass;
        logic [3:0]  neg;
        t_lane [7:0] ln;
    } t_dvs;

    typedef struct packed {
        logic [1:0]  ctrl;
        logic [15:0] ldx;
        logic [15:0] ldy;
        logic [15:0] lmag;
        logic [15:0] rdx;
        logic [15:0] rdy;
        logic [15:0] rmag;
        logic [15:0] llev;
        logic [15:0] rlev;
        logic [15:0] btn;
        logic [3:0]  flags;
        logic [31:0] pkt;
    } t_res;

    function automatic t_axis axis_prep(logic [15:0] x, logic [15:0] y);
        t_axis a;
        a.neg_x = x[15];
        a.neg_y = y[15];
        a.ax = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
        a.ay = y[15] ? (17'd0 - {y[15], y}) : {1'b0, y};
        return a;
    endfunction

    // (t - th) * 65535 as (d << 16) - d; inactive trigger divides 0 by 1
    function automatic t_trig trig_prep(logic [7:0] t, logic [7:0] th);
        t_trig r;
        logic [7:0] d;
        d = t - th;
        if (t > th) begin
            r.num = {d, 16'd0} - {16'd0, d};
            r.den = TRIG_FULL - th;
        end else begin
            r.num = '0;
            r.den = 8'd1;
        end
        return r;
    endfunction

    // one digit of the restoring square root
    function automatic t_root root_step(t_root a);
        t_root b;
        logic [18:0] rr;
        logic [18:0] trial;
        rr = {a.rem, a.s_sh[31:30]};
        trial = {1'b0, a.root, 2'b01};
        b.s_sh = {a.s_sh[29:0], 2'b00};
        if (rr >= trial) begin
            b.rem = 17'(rr - trial);
            b.root = {a.root[14:0], 1'b1};
        end else begin
            b.rem = rr[16:0];
            b.root = {a.root[14:0], 1'b0};
        end
        return b;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_lane lane_step(t_lane a);
        t_lane b;
        logic [16:0] rr;
        rr = {a.rem, a.num[15]};
        b.den = a.den;
        b.num = {a.num[14:0], 1'b0};
        if (rr >= {1'b0, a.den}) begin
            b.rem = 16'(rr - {1'b0, a.den});
            b.q = {a.q[14:0], 1'b1};
        end else begin
            b.rem = rr[15:0];
            b.q = {a.q[14:0], 1'b0};
        end
        return b;
    endfunction

    // quotient must fit 16 bits: num[31:16] < den
    function automatic t_lane lane_init(logic [31:0] num, logic [15:0] den, logic en);
        t_lane l;
        l.q = '0;
        if (en) begin
            l.rem = num[31:16];
            l.num = num[15:0];
            l.den = den;
        end else begin
            l.rem = '0;
            l.num = '0;
            l.den = 16'd1;
        end
        return l;
    endfunction

    function automatic logic [15:0] dir_out(logic [15:0] q, logic neg);
        logic [15:0] s;
        s = (q > DIR_LIMIT) ? DIR_LIMIT : q;
        return neg ? (16'd0 - s) : s;
    endfunction

endpackage

FILE: design/gamepad_stick_trigger_normalizer.sv
// Top level of the gamepad stick and trigger normalizer.
// Throughput: one item per cycle unless a valid result is held by an output stall;
// a 16-stage square root and 16-stage dividers run fully pipelined.
// A stall on a valid result freezes the pipeline; the input stall follows it in the same cycle.
// Reset (synchronous, active low) clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps

module gamepad_stick_trigger_normalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_controller_index,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [7:0]         i_left_pull,
    input  logic [7:0]         i_right_pull,
    input  logic [15:0]        i_button_bits,
    input  logic [31:0]        i_packet_number,
    // result items
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_report_controller,
    output logic signed [15:0] o_left_dir_x,
    output logic signed [15:0] o_left_dir_y,
    output logic [15:0]        o_left_magnitude,
    output logic signed [15:0] o_right_dir_x,
    output logic signed [15:0] o_right_dir_y,
    output logic [15:0]        o_right_magnitude,
    output logic [15:0]        o_left_level,
    output logic [15:0]        o_right_level,
    output logic [15:0]        o_buttons_out,
    output logic [3:0]         o_activity_flags,
    output logic [31:0]        o_generation,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);

    // config registers
    logic [14:0] r_left_dz;
    logic [14:0] r_right_dz;
    logic [7:0]  r_trig_th;
    logic [1:0][14:0] w_dz;

    assign o_cfg_ready = 1'b1;
    assign w_dz[0] = r_left_dz;
    assign w_dz[1] = r_right_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz  <= gsn_pkg::LEFT_DZ_RST;
            r_right_dz <= gsn_pkg::RIGHT_DZ_RST;
            r_trig_th  <= gsn_pkg::TRIG_TH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gsn_pkg::CFG_LEFT_DZ:  r_left_dz  <= i_cfg_data;
                gsn_pkg::CFG_RIGHT_DZ: r_right_dz <= i_cfg_data;
                gsn_pkg::CFG_TRIG_TH:  r_trig_th  <= i_cfg_data[7:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // pipeline control: one global advance; bubbles ride along as cleared valid bits
    logic [gsn_pkg::STAGES-1:0] r_vld;
    logic w_adv;
    logic w_in_acc;

    assign o_valid  = r_vld[gsn_pkg::STAGES-1];
    assign w_adv    = !(o_valid && i_stall);
    assign o_stall  = !w_adv;
    assign w_in_acc = i_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[gsn_pkg::STAGES-2:0], w_in_acc};
        end
    end

    // stage registers
    gsn_pkg::t_sa  r_sa, n_sa;
    gsn_pkg::t_sb  r_sb, n_sb;
    gsn_pkg::t_sqs r_sc, n_sc;
    gsn_pkg::t_sqs r_sq [gsn_pkg::ROOT_STEPS];
    gsn_pkg::t_dvs r_sd, n_sd;
    gsn_pkg::t_dvs r_dv [gsn_pkg::DIV_STEPS];
    gsn_pkg::t_res r_out, n_out;

    // stage A: absolute values, trigger numerators
    always_comb begin
        n_sa.pass.ctrl = i_controller_index;
        n_sa.pass.btn  = i_button_bits;
        n_sa.pass.pkt  = i_packet_number;
        n_sa.trg[0] = gsn_pkg::trig_prep(i_left_pull, r_trig_th);
        n_sa.trg[1] = gsn_pkg::trig_prep(i_right_pull, r_trig_th);
        n_sa.st[0]  = gsn_pkg::axis_prep(i_left_x, i_left_y);
        n_sa.st[1]  = gsn_pkg::axis_prep(i_right_x, i_right_y);
    end

    // stage B: squares and deadzone squared
    always_comb begin
        n_sb.pass = r_sa.pass;
        n_sb.trg  = r_sa.trg;
        n_sb.st   = r_sa.st;
        for (int k = 0; k < 2; k++) begin
            n_sb.sxx[k] = {14'd0, r_sa.st[k].ax} * {14'd0, r_sa.st[k].ax};
            n_sb.syy[k] = {14'd0, r_sa.st[k].ay} * {14'd0, r_sa.st[k].ay};
            n_sb.dz2[k] = {15'd0, w_dz[k]} * {15'd0, w_dz[k]};
        end
    end

    // stage C: sum of squares, deadzone test, root init
    always_comb begin
        logic [31:0] s;
        n_sc.pass = r_sb.pass;
        n_sc.trg  = r_sb.trg;
        n_sc.st   = r_sb.st;
        for (int k = 0; k < 2; k++) begin
            s = {1'b0, r_sb.sxx[k]} + {1'b0, r_sb.syy[k]};
            n_sc.act[k] = s > {2'd0, r_sb.dz2[k]};
            n_sc.rt[k].s_sh = s;
            n_sc.rt[k].rem  = '0;
            n_sc.rt[k].root = '0;
        end
    end

    // stage D: divider setup for directions, magnitudes and triggers
    always_comb begin
        gsn_pkg::t_sqs p;
        logic [14:0] c;
        logic [14:0] diff;
        logic [30:0] mnum;
        logic        mact;
        p = r_sq[gsn_pkg::ROOT_STEPS-1];
        n_sd.pass = p.pass;
        for (int k = 0; k < 2; k++) begin
            c = (p.rt[k].root > {1'b0, gsn_pkg::STICK_FULL}) ? gsn_pkg::STICK_FULL
                                                              : p.rt[k].root[14:0];
            diff = c - w_dz[k];
            mnum = {diff, 16'd0} - {16'd0, diff};
            mact = p.act[k] && (w_dz[k] != gsn_pkg::STICK_FULL) && (c > w_dz[k]);
            n_sd.neg[2*k]   = p.st[k].neg_x;
            n_sd.neg[2*k+1] = p.st[k].neg_y;
            // |axis| * 32768 / root; the root is at least 1 when active
            n_sd.ln[3*k]   = gsn_pkg::lane_init({p.st[k].ax, 15'd0}, p.rt[k].root, p.act[k]);
            n_sd.ln[3*k+1] = gsn_pkg::lane_init({p.st[k].ay, 15'd0}, p.rt[k].root, p.act[k]);
            n_sd.ln[3*k+2] = gsn_pkg::lane_init({1'b0, mnum},
                                                {1'b0, gsn_pkg::STICK_FULL - w_dz[k]}, mact);
        end
        n_sd.ln[gsn_pkg::LN_TL] = gsn_pkg::lane_init({8'd0, p.trg[0].num},
                                                     {8'd0, p.trg[0].den}, 1'b1);
        n_sd.ln[gsn_pkg::LN_TR] = gsn_pkg::lane_init({8'd0, p.trg[1].num},
                                                     {8'd0, p.trg[1].den}, 1'b1);
    end

    // output stage: saturate and sign directions, build flags
    always_comb begin
        gsn_pkg::t_dvs p;
        p = r_dv[gsn_pkg::DIV_STEPS-1];
        n_out.ctrl = p.pass.ctrl;
        n_out.btn  = p.pass.btn;
        n_out.pkt  = p.pass.pkt;
        n_out.ldx  = gsn_pkg::dir_out(p.ln[gsn_pkg::LN_LX].q, p.neg[0]);
        n_out.ldy  = gsn_pkg::dir_out(p.ln[gsn_pkg::LN_LY].q, p.neg[1]);
        n_out.rdx  = gsn_pkg::dir_out(p.ln[gsn_pkg::LN_RX].q, p.neg[2]);
        n_out.rdy  = gsn_pkg::dir_out(p.ln[gsn_pkg::LN_RY].q, p.neg[3]);
        n_out.lmag = p.ln[gsn_pkg::LN_LM].q;
        n_out.rmag = p.ln[gsn_pkg::LN_RM].q;
        n_out.llev = p.ln[gsn_pkg::LN_TL].q;
        n_out.rlev = p.ln[gsn_pkg::LN_TR].q;
        n_out.flags = {p.ln[gsn_pkg::LN_TR].q != 16'd0, p.ln[gsn_pkg::LN_TL].q != 16'd0,
                       p.ln[gsn_pkg::LN_RM].q != 16'd0, p.ln[gsn_pkg::LN_LM].q != 16'd0};
    end

    // payload registers: no reset, move only on advance
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
            r_sc <= n_sc;
            r_sq[0].pass <= r_sc.pass;
            r_sq[0].trg  <= r_sc.trg;
            r_sq[0].st   <= r_sc.st;
            r_sq[0].act  <= r_sc.act;
            for (int k = 0; k < 2; k++) begin
                r_sq[0].rt[k] <= gsn_pkg::root_step(r_sc.rt[k]);
            end
            for (int i = 1; i < gsn_pkg::ROOT_STEPS; i++) begin
                r_sq[i].pass <= r_sq[i-1].pass;
                r_sq[i].trg  <= r_sq[i-1].trg;
                r_sq[i].st   <= r_sq[i-1].st;
                r_sq[i].act  <= r_sq[i-1].act;
                for (int k = 0; k < 2; k++) begin
                    r_sq[i].rt[k] <= gsn_pkg::root_step(r_sq[i-1].rt[k]);
                end
            end
            r_sd <= n_sd;
            r_dv[0].pass <= r_sd.pass;
            r_dv[0].neg  <= r_sd.neg;
            for (int j = 0; j < 8; j++) begin
                r_dv[0].ln[j] <= gsn_pkg::lane_step(r_sd.ln[j]);
            end
            for (int i = 1; i < gsn_pkg::DIV_STEPS; i++) begin
                r_dv[i].pass <= r_dv[i-1].pass;
                r_dv[i].neg  <= r_dv[i-1].neg;
                for (int j = 0; j < 8; j++) begin
                    r_dv[i].ln[j] <= gsn_pkg::lane_step(r_dv[i-1].ln[j]);
                end
            end
            r_out <= n_out;
        end
    end

    assign o_report_controller = r_out.ctrl;
    assign o_left_dir_x        = r_out.ldx;
    assign o_left_dir_y        = r_out.ldy;
    assign o_left_magnitude    = r_out.lmag;
    assign o_right_dir_x       = r_out.rdx;
    assign o_right_dir_y       = r_out.rdy;
    assign o_right_magnitude   = r_out.rmag;
    assign o_left_level        = r_out.llev;
    assign o_right_level       = r_out.rlev;
    assign o_buttons_out       = r_out.btn;
    assign o_activity_flags    = r_out.flags;
    assign o_generation        = r_out.pkt;

`ifndef SYNTHESIS
    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stick past the deadzone always points somewhere
    a_left_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_left_magnitude != 16'd0 |-> (o_left_dir_x != 16'sd0 || o_left_dir_y != 16'sd0))
        else $error("left magnitude without direction");

    // direction saturation must never yield the most negative code
    a_left_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_dir_x != 16'sh8000 && o_left_dir_y != 16'sh8000))
        else $error("left direction out of range");

    a_right_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_right_dir_x != 16'sh8000 && o_right_dir_y != 16'sh8000))
        else $error("right direction out of range");
`endif

endmodule

FILE: bench/gamepad_stick_trigger_normalizer_test.sv
// Self-checking bench for the gamepad stick and trigger normalizer.
`timescale 1ns / 1ps

module gamepad_stick_trigger_normalizer_test;

    // register index that no register uses
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // one normalized report as the block should emit it
    typedef struct packed {
        logic [1:0]  ctrl;
        logic [15:0] ldx;
        logic [15:0] ldy;
        logic [15:0] lmag;
        logic [15:0] rdx;
        logic [15:0] rdy;
        logic [15:0] rmag;
        logic [15:0] llev;
        logic [15:0] rlev;
        logic [15:0] btn;
        logic [3:0]  flags;
        logic [31:0] pkt;
    } t_norm_report;

    int mismatches = 0;

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    // integer square root by bit search
    function automatic longint unsigned root_of(longint unsigned s);
        longint unsigned r;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= s) r = r + (64'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_axis(logic signed [15:0] v, longint unsigned r);
        longint unsigned a;
        longint unsigned q;
        a = (v < 0) ? longint'(-int'(v)) : longint'(v);
        q = (a * 32768) / r;
        if (q > 32767) q = 32767;
        return (v < 0) ? 16'(17'h10000 - q) : 16'(q);
    endfunction

    // direction x, direction y, magnitude for one stick
    function automatic logic [47:0] stick_norm(logic signed [15:0] x, logic signed [15:0] y,
                                               logic [14:0] dz);
        longint unsigned s;
        longint unsigned r;
        longint unsigned c;
        logic [15:0] m;
        s = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y));
        if (s <= longint'(dz) * longint'(dz)) return '0;
        r = root_of(s);
        c = (r < 32767) ? r : 32767;
        m = 0;
        if (dz < 15'h7fff && c > dz) m = 16'(((c - dz) * 65535) / (32767 - dz));
        return {unit_axis(x, r), unit_axis(y, r), m};
    endfunction

    function automatic logic [15:0] trig_norm(logic [7:0] t, logic [7:0] th);
        if (t <= th || th == 8'hff) return 0;
        return 16'((int'(t - th) * 65535) / (255 - th));
    endfunction

    // scoreboard: predicts on accepted input, checks on accepted result
    class t_norm_scoreboard;
        logic [14:0] left_dz, right_dz;
        logic [7:0] trig_th;
        t_norm_report pending[$];
        int checked;

        function void note_input(logic [1:0] ci, logic signed [15:0] lx, logic signed [15:0] ly,
                                 logic signed [15:0] rx, logic signed [15:0] ry,
                                 logic [7:0] lp, logic [7:0] rp, logic [15:0] bb,
                                 logic [31:0] pn);
            t_norm_report e;
            e.ctrl = ci;
            {e.ldx, e.ldy, e.lmag} = stick_norm(lx, ly, left_dz);
            {e.rdx, e.rdy, e.rmag} = stick_norm(rx, ry, right_dz);
            e.llev = trig_norm(lp, trig_th);
            e.rlev = trig_norm(rp, trig_th);
            e.btn = bb;
            e.flags = {e.rlev != 0, e.llev != 0, e.rmag != 0, e.lmag != 0};
            e.pkt = pn;
            pending.insert(pending.size(), e);
        endfunction

        task check_result(t_norm_report g);
            t_norm_report e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (g.ctrl != e.ctrl) report_mismatch("controller", g.ctrl, e.ctrl);
            if (g.ldx != e.ldx) report_mismatch("left_dir_x", g.ldx, e.ldx);
            if (g.ldy != e.ldy) report_mismatch("left_dir_y", g.ldy, e.ldy);
            if (g.lmag != e.lmag) report_mismatch("left_magnitude", g.lmag, e.lmag);
            if (g.rdx != e.rdx) report_mismatch("right_dir_x", g.rdx, e.rdx);
            if (g.rdy != e.rdy) report_mismatch("right_dir_y", g.rdy, e.rdy);
            if (g.rmag != e.rmag) report_mismatch("right_magnitude", g.rmag, e.rmag);
            if (g.llev != e.llev) report_mismatch("left_level", g.llev, e.llev);
            if (g.rlev != e.rlev) report_mismatch("right_level", g.rlev, e.rlev);
            if (g.btn != e.btn) report_mismatch("buttons", g.btn, e.btn);
            if (g.flags != e.flags) report_mismatch("flags", g.flags, e.flags);
            if (g.pkt != e.pkt) report_mismatch("generation", g.pkt, e.pkt);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [1:0] i_controller_index = 0;
    logic signed [15:0] i_left_x = 0, i_left_y = 0, i_right_x = 0, i_right_y = 0;
    logic [7:0] i_left_pull = 0, i_right_pull = 0;
    logic [15:0] i_button_bits = 0;
    logic [31:0] i_packet_number = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [1:0] o_report_controller;
    logic signed [15:0] o_left_dir_x, o_left_dir_y, o_right_dir_x, o_right_dir_y;
    logic [15:0] o_left_magnitude, o_right_magnitude, o_left_level, o_right_level;
    logic [15:0] o_buttons_out;
    logic [3:0] o_activity_flags;
    logic [31:0] o_generation;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = 0;
    logic [14:0] i_cfg_data = 0;

    gamepad_stick_trigger_normalizer dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    t_norm_scoreboard board = new();
    bit idle_on = 1;     // random input gaps and receiver stalls enabled
    bit feeding = 0;
    int sent = 0;

    // outputs sampled at the edge; predictions made at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_input(i_controller_index, i_left_x, i_left_y, i_right_x, i_right_y,
                                 i_left_pull, i_right_pull, i_button_bits, i_packet_number);
            if (o_valid && !i_stall)
                board.check_result({o_report_controller, o_left_dir_x, o_left_dir_y,
                                    o_left_magnitude, o_right_dir_x, o_right_dir_y,
                                    o_right_magnitude, o_left_level, o_right_level,
                                    o_buttons_out, o_activity_flags, o_generation});
            // receiver stall, redrawn each cycle
            i_stall <= idle_on && ($urandom_range(99) < 24);
        end
    end

    // present one report, hold it until taken; random idle cycles before it
    task automatic send_report(logic [1:0] ci, logic [15:0] lx, logic [15:0] ly,
                               logic [15:0] rx, logic [15:0] ry, logic [7:0] lp,
                               logic [7:0] rp, logic [15:0] bb);
        while (idle_on && $urandom_range(99) < 24) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_controller_index <= ci;
        i_left_x <= lx;
        i_left_y <= ly;
        i_right_x <= rx;
        i_right_y <= ry;
        i_left_pull <= lp;
        i_right_pull <= rp;
        i_button_bits <= bb;
        i_packet_number <= $urandom;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic go_quiet();
        i_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (gsn_pkg::STAGES + 5) @(posedge i_clk);
    endtask

    // register write; only called with the pipeline drained
    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == gsn_pkg::CFG_LEFT_DZ) board.left_dz = val;
        else if (idx == gsn_pkg::CFG_RIGHT_DZ) board.right_dz = val;
        else if (idx == gsn_pkg::CFG_TRIG_TH) board.trig_th = val[7:0];
        @(posedge i_clk);
    endtask

    // random axis: mostly full range, some small values inside the deadzone
    function automatic logic [15:0] rand_axis(logic [14:0] dz);
        case ($urandom_range(3))
            0: return 16'($urandom_range(dz + 2) - (dz + 2) / 2);
            1: return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_batch(int n);
        logic [7:0] th;
        repeat (n) begin
            th = board.trig_th;
            send_report(2'($urandom), rand_axis(board.left_dz), rand_axis(board.left_dz),
                        rand_axis(board.right_dz), rand_axis(board.right_dz),
                        8'($urandom_range(3) == 0 ? th + $urandom_range(1) : $urandom),
                        8'($urandom_range(3) == 0 ? th : $urandom), 16'($urandom));
        end
    endtask

    initial begin
        board.left_dz = gsn_pkg::LEFT_DZ_RST;
        board.right_dz = gsn_pkg::RIGHT_DZ_RST;
        board.trig_th = gsn_pkg::TRIG_TH_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes at reset settings
        send_report(2'd0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 8'd255, 8'd255,
                    16'hffff);
        send_report(2'd3, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0);
        send_report(2'd1, 16'sh8000, 16'd0, 16'd0, 16'sh8000, 8'd30, 8'd31, 16'h5a5a);
        // on the circle: inside
        send_report(2'd2, 16'sd7849, 16'd0, 16'd0, 16'sd8689, 8'd31, 8'd30, 16'ha5a5);
        // root equals deadzone
        send_report(2'd1, 16'sd7849, 16'd1, 16'sd8689, 16'd1, 8'd254, 8'd1, 16'd1);
        send_report(2'd2, -16'sd7850, 16'd0, 16'd0, -16'sd8690, 8'd29, 8'd200, 16'd2);
        send_report(2'd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 8'd128, 8'd64,
                    16'h8000);
        go_quiet();

        // directed: deadzone at its extremes, threshold at its extremes
        write_reg(gsn_pkg::CFG_LEFT_DZ, 15'd0);
        write_reg(gsn_pkg::CFG_RIGHT_DZ, 15'd32766);
        write_reg(gsn_pkg::CFG_TRIG_TH, 15'd0);
        send_report(2'd0, 16'd1, 16'd0, 16'sh7fff, 16'sh7fff, 8'd1, 8'd0, 16'd0);
        send_report(2'd1, 16'd0, -16'sd1, 16'sd32766, 16'd1, 8'd255, 8'd1, 16'd0);
        send_report(2'd2, 16'd0, 16'd0, 16'sh8000, 16'd0, 8'd0, 8'd255, 16'd0);
        go_quiet();
        write_reg(gsn_pkg::CFG_LEFT_DZ, 15'h7fff);   // full-scale deadzone: no magnitude
        write_reg(gsn_pkg::CFG_RIGHT_DZ, 15'd1);
        write_reg(gsn_pkg::CFG_TRIG_TH, 15'd254);
        send_report(2'd3, 16'sh8000, 16'sh8000, 16'd1, 16'd1, 8'd255, 8'd254, 16'd0);
        send_report(2'd0, 16'sh7fff, 16'sh7fff, 16'd0, 16'd1, 8'd254, 8'd255, 16'd0);
        go_quiet();
        write_reg(gsn_pkg::CFG_TRIG_TH, 15'd255);    // out-of-range threshold
        write_reg(CFG_SPARE, 15'h1234);              // unknown index, ignored
        send_report(2'd1, 16'd100, 16'd200, 16'd300, 16'd400, 8'd255, 8'd255, 16'd0);
        go_quiet();

        // random phases across several settings; one phase without idling
        write_reg(gsn_pkg::CFG_LEFT_DZ, gsn_pkg::LEFT_DZ_RST);
        write_reg(gsn_pkg::CFG_RIGHT_DZ, gsn_pkg::RIGHT_DZ_RST);
        write_reg(gsn_pkg::CFG_TRIG_TH, {7'd0, gsn_pkg::TRIG_TH_RST});
        random_batch(130);
        go_quiet();   // sender holds off until all results are back
        idle_on = 0;
        random_batch(120);
        go_quiet();
        idle_on = 1;
        for (int p = 0; p < 3; p++) begin
            write_reg(gsn_pkg::CFG_LEFT_DZ, 15'($urandom_range(32766)));
            write_reg(gsn_pkg::CFG_RIGHT_DZ, 15'($urandom_range(2000)));
            write_reg(gsn_pkg::CFG_TRIG_TH, 15'($urandom_range(254)));
            random_batch(100);
            go_quiet();
        end

        $display("covered %0d reports, %0d results checked, deadzone and threshold extremes",
                 sent, board.checked);
        if (mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS gamepad_stick_trigger_normalizer");
        end else begin
            $display("FAIL gamepad_stick_trigger_normalizer");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL gamepad_stick_trigger_normalizer");
        $finish;
    end
endmodule
